>>> src/ps2m_pkg.sv
// Shared types, status and header bit positions, and the axis decode for
// the PS/2 mouse packet receiver. No dependencies.
package ps2m_pkg;

    typedef logic [7:0] byte_t;

    // Item codes on the op field
    localparam logic OP_IRQ = 1'b0;
    localparam logic OP_POP = 1'b1;

    // Controller status bits
    localparam int ST_OBF_BIT = 0;
    localparam int ST_AUX_BIT = 5;

    // Packet header bits
    localparam int HDR_BTN_L_BIT = 0;
    localparam int HDR_BTN_R_BIT = 1;
    localparam int HDR_BTN_M_BIT = 2;
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSGN_BIT  = 4;
    localparam int HDR_YSGN_BIT  = 5;
    localparam int HDR_XOVF_BIT  = 6;
    localparam int HDR_YOVF_BIT  = 7;

    // Strobes from the sequencer to the ring memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ring_ctl_t;

    // Nine-bit signed movement; an overflowed axis reads as zero
    function automatic logic signed [8:0] axis_value(input byte_t raw, input logic ovf,
                                                     input logic neg);
        logic signed [8:0] v;
        v = $signed({neg, raw});
        if (ovf)
        begin
            v = '0;
        end
        return v;
    endfunction

endpackage

>>> src/ps2m_ring.sv
// Byte ring storage: one write port and one read port with registered read data.
// Depends on ps2m_pkg.
module ps2m_ring
    import ps2m_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic            clk,
    input  ring_ctl_t       ctl,
    input  logic [AW-1:0]   wr_addr,
    input  byte_t           wr_data,
    input  logic [AW-1:0]   rd_addr,
    output byte_t           rd_data
);

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/ps2m_core.sv
// Sequencer for the PS/2 mouse receiver: pointers, fill count, counters and
// packet decode around the ring memory. Depends on ps2m_pkg and ps2m_ring.
module ps2m_core
    import ps2m_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [7:0]        ctrl_status,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              packet_valid,
    output logic signed [8:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic              btn_left,
    output logic              btn_right,
    output logic              btn_middle,
    output logic [8:0]        pending_bytes,
    output logic [31:0]       dropped_total,
    output logic [31:0]       resync_total,
    output logic [31:0]       irq_total
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(RING_DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);
    localparam logic [CW-1:0] THREE_CNT = CW'(3);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_RX   = 2'd2;
    localparam logic [1:0] S_RY   = 2'd3;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
        logic [AW-1:0] r;
        r = idx + 1'b1;
        if (idx == LAST_IDX)
        begin
            r = '0;
        end
        return r;
    endfunction

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     wr_idx_reg, wr_idx_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     scan_idx_reg, scan_idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [31:0]       drop_reg, drop_next;
    logic [31:0]       resync_reg, resync_next;
    logic [31:0]       irq_reg, irq_next;
    byte_t             hdr_reg, hdr_next;
    byte_t             rx_reg, rx_next;
    logic              out_valid_reg, out_valid_next;
    logic              pv_reg, pv_next;
    logic signed [8:0] dx_reg, dx_next;
    logic signed [8:0] dy_reg, dy_next;
    logic [2:0]        btn_reg, btn_next;

    ring_ctl_t         ring_ctl;
    logic [AW-1:0]     ring_rd_addr;
    byte_t             ring_rd_data;
    logic              accept;
    logic              finish;
    logic [CW+8:0]     pend_ext;

    ps2m_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .ctl     (ring_ctl),
        .wr_addr (wr_idx_reg),
        .wr_data (rx_byte),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    // one word in flight; a new one enters as the last result leaves
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        scan_idx_next = scan_idx_reg;
        count_next    = count_reg;
        drop_next     = drop_reg;
        resync_next   = resync_reg;
        irq_next      = irq_reg;
        hdr_next      = hdr_reg;
        rx_next       = rx_reg;
        ring_ctl      = '0;
        ring_rd_addr  = rd_idx_reg;
        finish        = 1'b0;
        pv_next       = 1'b0;
        dx_next       = '0;
        dy_next       = '0;
        btn_next      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_IRQ)
                    begin
                        irq_next = irq_reg + 32'd1;
                        if (ctrl_status[ST_OBF_BIT] && ctrl_status[ST_AUX_BIT])
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                drop_next = drop_reg + 32'd1;
                            end
                            else
                            begin
                                ring_ctl.wr_en = 1'b1;
                                wr_idx_next    = idx_inc(wr_idx_reg);
                                count_next     = count_reg + ONE_CNT;
                            end
                        end
                        finish = 1'b1;
                    end
                    else if (count_reg != '0)
                    begin
                        ring_ctl.rd_en = 1'b1;
                        state_next     = S_CHK;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end

            // read data holds the byte at the read index
            S_CHK:
            begin
                if (!ring_rd_data[HDR_SYNC_BIT])
                begin
                    rd_idx_next = idx_inc(rd_idx_reg);
                    count_next  = count_reg - ONE_CNT;
                    resync_next = resync_reg + 32'd1;
                    if (count_reg != ONE_CNT)
                    begin
                        ring_ctl.rd_en = 1'b1;
                        ring_rd_addr   = rd_idx_next;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (count_reg < THREE_CNT)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    hdr_next       = ring_rd_data;
                    scan_idx_next  = idx_inc(rd_idx_reg);
                    ring_ctl.rd_en = 1'b1;
                    ring_rd_addr   = scan_idx_next;
                    state_next     = S_RX;
                end
            end

            S_RX:
            begin
                rx_next        = ring_rd_data;
                scan_idx_next  = idx_inc(scan_idx_reg);
                ring_ctl.rd_en = 1'b1;
                ring_rd_addr   = scan_idx_next;
                state_next     = S_RY;
            end

            S_RY:
            begin
                rd_idx_next = idx_inc(scan_idx_reg);
                count_next  = count_reg - THREE_CNT;
                pv_next     = 1'b1;
                dx_next     = axis_value(rx_reg, hdr_reg[HDR_XOVF_BIT], hdr_reg[HDR_XSGN_BIT]);
                dy_next     = axis_value(ring_rd_data, hdr_reg[HDR_YOVF_BIT],
                                         hdr_reg[HDR_YSGN_BIT]);
                btn_next    = {hdr_reg[HDR_BTN_M_BIT], hdr_reg[HDR_BTN_R_BIT],
                               hdr_reg[HDR_BTN_L_BIT]};
                finish      = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            count_reg     <= '0;
            drop_reg      <= '0;
            resync_reg    <= '0;
            irq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            resync_reg    <= resync_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        hdr_reg      <= hdr_next;
        rx_reg       <= rx_next;
        if (finish)
        begin
            pv_reg  <= pv_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            btn_reg <= btn_next;
        end
    end

    // counters are quiet while a result waits, so they drive the port directly
    assign pend_ext      = {9'd0, count_reg};
    assign out_valid     = out_valid_reg;
    assign packet_valid  = pv_reg;
    assign delta_x       = dx_reg;
    assign delta_y       = dy_reg;
    assign btn_left      = btn_reg[0];
    assign btn_right     = btn_reg[1];
    assign btn_middle    = btn_reg[2];
    assign pending_bytes = pend_ext[8:0];
    assign dropped_total = drop_reg;
    assign resync_total  = resync_reg;
    assign irq_total     = irq_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("ring fill count above depth");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_ctl.wr_en && ring_ctl.rd_en))
        else $error("ring read and write in the same cycle");

    a_irq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_IRQ) |=> (irq_reg == $past(irq_reg) + 32'd1))
        else $error("interrupt word not counted");

    a_resync_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CHK) |=> $stable(resync_reg))
        else $error("resync count moved outside header search");

    a_pop_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RY) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("packet read did not produce a result");
`endif

endmodule

>>> src/ps2_mouse_packet_receiver_core.sv
// PS/2 mouse packet receiver, top level. One word is in flight at a time, and a
// new word enters only as the previous result leaves. An interrupt word finishes
// at once, with at most one ring write. A pop word finishes at once when the ring
// is empty; otherwise it examines ring bytes one at a time through the single
// registered read port, skipping non-header bytes, and ends when the skipping
// empties the ring, when a header leads with fewer than three bytes buffered, or
// after reading the header, x and y bytes of a complete packet.
// Depends on ps2m_pkg and ps2m_core.
module ps2_mouse_packet_receiver_core
    import ps2m_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [7:0]        ctrl_status,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              packet_valid,
    output logic signed [8:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic              btn_left,
    output logic              btn_right,
    output logic              btn_middle,
    output logic [8:0]        pending_bytes,
    output logic [31:0]       dropped_total,
    output logic [31:0]       resync_total,
    output logic [31:0]       irq_total
);

    ps2m_core #(
        .RING_DEPTH (RING_DEPTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .ctrl_status   (ctrl_status),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_valid  (packet_valid),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .btn_left      (btn_left),
        .btn_right     (btn_right),
        .btn_middle    (btn_middle),
        .pending_bytes (pending_bytes),
        .dropped_total (dropped_total),
        .resync_total  (resync_total),
        .irq_total     (irq_total)
    );

endmodule

>>> tb/tb_ps2_mouse_packet_receiver_core.sv
// Self-checking testbench for ps2_mouse_packet_receiver_core: random-paced words
// on both channels, results checked in order against a built-in packet decoder.
// Depends on ps2m_pkg and the receiver RTL.
module tb_ps2_mouse_packet_receiver_core;
    import ps2m_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RING_SIZE = 256;
    localparam byte_t ST_PUSH   = byte_t'((1 << ST_OBF_BIT) | (1 << ST_AUX_BIT));
    localparam byte_t SYNC_MASK = byte_t'(1 << HDR_SYNC_BIT);

    // One result word as the block reports it
    typedef struct packed {
        logic              pv;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic              bl;
        logic              br;
        logic              bm;
        logic [8:0]        pend;
        logic [31:0]       drops;
        logic [31:0]       resyncs;
        logic [31:0]       irqs;
    } mouse_report_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              op = OP_IRQ;
    logic [7:0]        ctrl_status = 8'h00;
    logic [7:0]        rx_byte = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              packet_valid;
    logic signed [8:0] delta_x;
    logic signed [8:0] delta_y;
    logic              btn_left;
    logic              btn_right;
    logic              btn_middle;
    logic [8:0]        pending_bytes;
    logic [31:0]       dropped_total;
    logic [31:0]       resync_total;
    logic [31:0]       irq_total;

    // Decoder state: byte ring, 9-bit pointers, wrapping counters
    byte_t       ring_mem [RING_SIZE];
    logic [8:0]  wr_idx = '0;
    logic [8:0]  rd_idx = '0;
    logic [31:0] drop_count = '0;
    logic [31:0] resync_count = '0;
    logic [31:0] irq_count = '0;

    mouse_report_t expected_reports [$];
    mouse_report_t got_report;
    mouse_report_t want_report;
    int            fail_count = 0;
    int            words_sent = 0;

    // Sender pacing
    int burst_left = 0;
    bit no_gaps = 1'b0;

    // Receiver pacing
    int ready_mode = 0;
    int ready_left = 0;
    int cycle_count = 0;

    ps2_mouse_packet_receiver_core #(
        .RING_DEPTH(RING_SIZE)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .ctrl_status  (ctrl_status),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_valid (packet_valid),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .btn_left     (btn_left),
        .btn_right    (btn_right),
        .btn_middle   (btn_middle),
        .pending_bytes(pending_bytes),
        .dropped_total(dropped_total),
        .resync_total (resync_total),
        .irq_total    (irq_total)
    );

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fill level; the pointers run modulo twice the depth
    function automatic logic [8:0] ring_fill();
        return wr_idx - rd_idx;
    endfunction

    // Apply one word to the decoder state and return the report it causes
    function automatic mouse_report_t decode_mouse_word(input logic o, input byte_t st,
                                                        input byte_t d);
        mouse_report_t r;
        byte_t         hdr;
        byte_t         bx;
        byte_t         by;
        logic [7:0]    rp;
        r = '0;
        if (o == OP_IRQ)
        begin
            irq_count = irq_count + 32'd1;
            if (st[ST_OBF_BIT] && st[ST_AUX_BIT])
            begin
                if (ring_fill() >= RING_SIZE)
                begin
                    drop_count = drop_count + 32'd1;
                end
                else
                begin
                    ring_mem[wr_idx[7:0]] = d;
                    wr_idx = wr_idx + 9'd1;
                end
            end
        end
        else
        begin
            // hunt for a header byte
            while (ring_fill() != 0 && !ring_mem[rd_idx[7:0]][HDR_SYNC_BIT])
            begin
                rd_idx = rd_idx + 9'd1;
                resync_count = resync_count + 32'd1;
            end
            if (ring_fill() >= 3)
            begin
                rp = rd_idx[7:0];
                hdr = ring_mem[rp];
                bx = ring_mem[rp + 8'd1];
                by = ring_mem[rp + 8'd2];
                rd_idx = rd_idx + 9'd3;
                r.pv = 1'b1;
                r.dx = hdr[HDR_XOVF_BIT] ? 9'sd0 : $signed({hdr[HDR_XSGN_BIT], bx});
                r.dy = hdr[HDR_YOVF_BIT] ? 9'sd0 : $signed({hdr[HDR_YSGN_BIT], by});
                r.bl = hdr[HDR_BTN_L_BIT];
                r.br = hdr[HDR_BTN_R_BIT];
                r.bm = hdr[HDR_BTN_M_BIT];
            end
        end
        r.pend = ring_fill();
        r.drops = drop_count;
        r.resyncs = resync_count;
        r.irqs = irq_count;
        return r;
    endfunction

    // Accepted inputs feed the decoder; accepted results are checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_reports.push_back(decode_mouse_word(op, ctrl_status, rx_byte));
            end
            if (out_valid && out_ready)
            begin
                got_report = '{packet_valid, delta_x, delta_y, btn_left, btn_right,
                               btn_middle, pending_bytes, dropped_total, resync_total,
                               irq_total};
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result word with nothing expected", $realtime);
                    end
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    if (got_report !== want_report)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("%0t: mismatch exp pv=%b dx=%0d dy=%0d btn=%b%b%b ",
                                   $realtime, want_report.pv, want_report.dx,
                                   want_report.dy, want_report.bm, want_report.br,
                                   want_report.bl);
                            $display("pend=%0d drop=%0d resync=%0d irq=%0d",
                                     want_report.pend, want_report.drops,
                                     want_report.resyncs, want_report.irqs);
                            $write("%0t:          got pv=%b dx=%0d dy=%0d btn=%b%b%b ",
                                   $realtime, got_report.pv, got_report.dx,
                                   got_report.dy, got_report.bm, got_report.br,
                                   got_report.bl);
                            $display("pend=%0d drop=%0d resync=%0d irq=%0d",
                                     got_report.pend, got_report.drops,
                                     got_report.resyncs, got_report.irqs);
                        end
                    end
                end
            end
        end
    end

    // Receiver stalls: phases of always-ready, light, heavy and periodic stalls
    always @(negedge clk)
    begin
        cycle_count++;
        if (ready_left == 0)
        begin
            ready_left = $urandom_range(8, 80);
            ready_mode = $urandom_range(0, 3);
        end
        ready_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 2) == 0);
            default: out_ready <= ((cycle_count % 7) < 4);
        endcase
    end

    // Send one word; entered and left at a falling edge
    task automatic send_word(input logic o, input byte_t st, input byte_t d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= o;
        ctrl_status <= st;
        rx_byte <= d;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic push_byte(input byte_t d);
        send_word(OP_IRQ, ST_PUSH | byte_t'($urandom_range(0, 255)), d);
    endtask

    // Unused fields of a pop carry random values
    task automatic pop_packet();
        send_word(OP_POP, byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
    endtask

    // Hold the sender off until every expected result has come back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_reports.size() != 0);
        burst_left = 0;
    endtask

    // Field extremes, ignored status codes, resync, partial and complete packets
    task automatic test_decode_directed();
        pop_packet();                         // empty ring
        send_word(OP_IRQ, 8'h00, 8'hFF);      // no status bits
        send_word(OP_IRQ, 8'h01, 8'hFF);      // output full only
        send_word(OP_IRQ, 8'h20, 8'hFF);      // auxiliary only
        send_word(OP_IRQ, 8'hDE, 8'hFF);      // every other bit
        send_word(OP_IRQ, ST_PUSH, 8'h00);    // non-header
        send_word(OP_IRQ, 8'hFF, 8'hF7);      // non-header, all other bits set
        push_byte(SYNC_MASK);
        push_byte(8'h00);
        pop_packet();                         // two resyncs, header stays buffered
        push_byte(8'hFF);
        pop_packet();                         // x = 0, y = 255
        push_byte(8'hFF);                     // both overflows, all buttons
        push_byte(8'hFF);
        push_byte(8'hFF);
        pop_packet();
        push_byte(8'h3F);                     // both signs, no overflow
        push_byte(8'h00);
        push_byte(8'h80);
        pop_packet();                         // x = -256, y = -128
        send_word(OP_IRQ, 8'h21, 8'h1A);
        send_word(OP_IRQ, 8'hFF, 8'hFF);
        send_word(OP_IRQ, 8'h21, 8'h01);
        pop_packet();
        pop_packet();                         // empty again
    endtask

    // Fill the ring to the brim, overrun it, then drain it with pops
    task automatic test_ring_overflow();
        int extra;
        pause_until_drained();
        no_gaps = 1'b1;
        while (ring_fill() < RING_SIZE)
        begin
            push_byte(byte_t'($urandom_range(0, 255)));
        end
        no_gaps = 1'b0;
        extra = $urandom_range(4, 10);
        repeat (extra) push_byte(byte_t'($urandom_range(0, 255)));
        send_word(OP_IRQ, 8'h01, 8'h55);      // ignored even when full
        // every pop here consumes at least one byte
        while (ring_fill() >= 3)
        begin
            pop_packet();
        end
        pop_packet();
        pause_until_drained();
    endtask

    // Mostly well-formed packets with random content, plus noise
    task automatic test_random_traffic(input int budget);
        int    start;
        int    pick;
        byte_t hdr;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            if ($urandom_range(0, 99) == 0)
            begin
                pause_until_drained();
            end
            if ($urandom_range(0, 59) == 0)
            begin
                no_gaps = ~no_gaps;
            end
            pick = $urandom_range(0, 99);
            hdr = byte_t'($urandom_range(0, 255)) | SYNC_MASK;
            if (pick < 35)
            begin
                push_byte(hdr);
                push_byte(byte_t'($urandom_range(0, 255)));
                push_byte(byte_t'($urandom_range(0, 255)));
            end
            else if (pick < 68)
            begin
                pop_packet();
            end
            else if (pick < 76)
            begin
                push_byte(byte_t'($urandom_range(0, 255)) & ~SYNC_MASK);
            end
            else if (pick < 82)
            begin
                // broken packet: header and one byte only
                push_byte(hdr);
                push_byte(byte_t'($urandom_range(0, 255)));
            end
            else if (pick < 92)
            begin
                send_word(OP_IRQ, byte_t'($urandom_range(0, 255)),
                          byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                push_byte(byte_t'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_decode_directed();
        pause_until_drained();
        test_ring_overflow();
        test_random_traffic(480);

        pause_until_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ps2_mouse_packet_receiver_core] OK");
        end
        else
        begin
            $display("[ps2_mouse_packet_receiver_core] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("[ps2_mouse_packet_receiver_core] ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/ps2m_pkg.sv
src/ps2m_ring.sv
src/ps2m_core.sv
src/ps2_mouse_packet_receiver_core.sv
tb/tb_ps2_mouse_packet_receiver_core.sv
